### src/gfwmac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfwmac_pkg: shared constants and field arithmetic
// Bus and symbol geometry and the GF(2^m) multiply for the word
// multiply-accumulate block.
// ----------------------------------------------------------------------------
package gfwmac_pkg;

	// Fixed field widths of the streams.
	localparam int DATA_BITS  = 64;
	localparam int COEF_BITS  = 8;
	localparam int IN_TDATA_W = DATA_BITS + COEF_BITS;

	// Geometry of the lanes inside the bus word.
	localparam int BUS_WIDTH   = 64;
	localparam int SYMBOL_BITS = 8;
	localparam int LANE_COUNT  = BUS_WIDTH / SYMBOL_BITS;
	localparam int LANE_BITS   = LANE_COUNT * SYMBOL_BITS;

	typedef logic [SYMBOL_BITS-1:0] sym_t;

	// Primitive polynomial of each supported field size.
	function automatic logic [8:0] poly_for(input int bits);
		logic [8:0] poly;
		case (bits)
			3:       poly = 9'h00B;
			4:       poly = 9'h013;
			5:       poly = 9'h025;
			6:       poly = 9'h043;
			7:       poly = 9'h089;
			default: poly = 9'h11D;
		endcase
		return poly;
	endfunction

	localparam logic [8:0] FIELD_POLY = poly_for(SYMBOL_BITS);
	localparam sym_t       POLY_LOW   = FIELD_POLY[SYMBOL_BITS-1:0];

	// Shift-and-add field multiply; a zero operand gives zero naturally.
	function automatic sym_t gf_mul(input sym_t a, input sym_t b);
		sym_t prod;
		sym_t x;
		prod = '0;
		x    = a;
		for (int i = 0; i < SYMBOL_BITS; i++) begin
			if (b[i]) begin
				prod = prod ^ x;
			end
			x = {x[SYMBOL_BITS-2:0], 1'b0} ^ (x[SYMBOL_BITS-1] ? POLY_LOW : '0);
		end
		return prod;
	endfunction

endpackage
`default_nettype wire

### src/gfwmac_word_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfwmac_word_mul: lane-wise field multiply of one bus word
// Splits the word into symbols from the top and scales each by the
// coefficient; the products are packed into the low bits, first lane highest.
// ----------------------------------------------------------------------------
module gfwmac_word_mul (
	input  wire logic [gfwmac_pkg::DATA_BITS-1:0] word,
	input  wire logic [gfwmac_pkg::COEF_BITS-1:0] coef,
	output logic      [gfwmac_pkg::DATA_BITS-1:0] product
);

	logic [gfwmac_pkg::LANE_COUNT-1:0][gfwmac_pkg::SYMBOL_BITS-1:0] lanes;
	gfwmac_pkg::sym_t coef_sym;

	assign coef_sym = coef[gfwmac_pkg::SYMBOL_BITS-1:0];

	for (genvar l = 0; l < gfwmac_pkg::LANE_COUNT; l++) begin : g_lane
		localparam int SH = gfwmac_pkg::BUS_WIDTH - gfwmac_pkg::SYMBOL_BITS * (l + 1);
		assign lanes[gfwmac_pkg::LANE_COUNT-1-l] =
			gfwmac_pkg::gf_mul(word[SH +: gfwmac_pkg::SYMBOL_BITS], coef_sym);
	end

	assign product = gfwmac_pkg::DATA_BITS'(lanes);

endmodule
`default_nettype wire

### src/gf256_word_multiply_accumulate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf256_word_multiply_accumulate: erasure-decoder combining step
// Multiplies each incoming bus word by its GF(2^8) coefficient and XORs the
// result into an accumulator, emitting the sum on the word marked last.
// ----------------------------------------------------------------------------
// The block accepts one request per clock cycle and sustains that rate
// indefinitely while the output side keeps taking results. Each accepted word
// is held in an input register; in the following cycle all eight byte lanes
// are multiplied by the coefficient in parallel (polynomial 0x11D) and folded
// into the accumulator. A request flagged with tlast closes the combination:
// its folded sum is written to the output register and the accumulator is
// cleared, so the result passes from the input register to the output
// register, where it is presented until the receiver takes it.
// The output register lets the next combination start while a result still
// waits; only when a second closing word reaches the input register before
// the first result has been taken does the input side stall.
module gf256_word_multiply_accumulate (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input request: tdata holds data_in [63:0] then coefficient [71:64].
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [71:0] s_axis_tdata,
	input  wire logic        s_axis_tlast,   // last_packet
	// Result: tdata holds data_out [63:0].
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [63:0] m_axis_tdata
);

	localparam int DW = gfwmac_pkg::DATA_BITS;
	localparam int CW = gfwmac_pkg::COEF_BITS;

	// Input register stage.
	logic          valid_s1;
	logic          last_s1;
	logic [DW-1:0] data_s1;
	logic [CW-1:0] coef_s1;

	// Accumulator and output register.
	logic [DW-1:0] acc_q;
	logic          out_valid_q;
	logic [DW-1:0] out_data_q;

	logic [DW-1:0] product;
	logic [DW-1:0] folded;
	logic          out_free;
	logic          advance;
	logic          accept;

	gfwmac_word_mul u_word_mul (
		.word    (data_s1),
		.coef    (coef_s1),
		.product (product)
	);

	assign folded   = acc_q ^ product;
	assign out_free = !out_valid_q || m_axis_tready;
	// A word that does not close a combination never needs the output register.
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept   = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= s_axis_tdata[DW-1:0];
			coef_s1 <= s_axis_tdata[DW+CW-1:DW];
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (advance) begin
			acc_q <= last_s1 ? '0 : folded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_data_q <= folded;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
	// An empty input register must always be able to take a request.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stage empty but not ready");

	// A closing word leaves the accumulator clear for the next combination.
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (acc_q == '0))
		else $error("accumulator not cleared after closing word");

	// A waiting result is never overwritten by the next closing word.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !(advance && last_s1))
		else $error("pending result overwritten");

	// A result stalled at the output keeps its value.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> $stable(out_data_q))
		else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

### tb/tb_gf256_word_multiply_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gf256_word_multiply_accumulate: self-checking bench for the GF(2^8) MAC
// Streams bus words with field coefficients into the block, predicts every
// closing sum with an independent lane-wise field multiply, and compares each
// result word as it leaves, under several patterns of stalls on both sides.
// ----------------------------------------------------------------------------
module tb_gf256_word_multiply_accumulate;

	// One input request: the bus word, its coefficient and the closing mark.
	typedef struct packed {
		logic [gfwmac_pkg::DATA_BITS-1:0] word;
		logic [gfwmac_pkg::COEF_BITS-1:0] coef;
		logic                             closes;
	} word_req_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_axis_tvalid = 1'b0;
	logic                              s_axis_tready;
	// data_in [63:0], coefficient [71:64]
	logic [gfwmac_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic                              s_axis_tlast = 1'b0; // last_packet
	logic                              m_axis_tvalid;
	logic                              m_axis_tready = 1'b0;
	logic [gfwmac_pkg::DATA_BITS-1:0]  m_axis_tdata;        // data_out [63:0]

	// Requests waiting for the driver, and the sums still owed by the block.
	word_req_t                        request_q[$];
	logic [gfwmac_pkg::DATA_BITS-1:0] expected_sums_q[$];

	// Running XOR of product words for the combination now being fed in.
	logic [gfwmac_pkg::DATA_BITS-1:0] running_sum = '0;

	logic req_taken = 1'b0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   error_count = 0;
	int   requests_taken = 0;
	int   sums_checked = 0;
	int   run_length = 0;
	int   longest_run = 0;

	gf256_word_multiply_accumulate u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// Field product of two symbols: the multiplicand is doubled once per bit of
	// the multiplier, and reduced by the full polynomial whenever it overflows.
	function automatic gfwmac_pkg::sym_t gf_mul_sym(input gfwmac_pkg::sym_t lhs,
			input gfwmac_pkg::sym_t rhs);
		logic [gfwmac_pkg::SYMBOL_BITS:0] doubled;
		gfwmac_pkg::sym_t                 acc;
		acc     = '0;
		doubled = {1'b0, lhs};
		for (int b = 0; b < gfwmac_pkg::SYMBOL_BITS; b++) begin
			if (rhs[b]) begin
				acc = acc ^ doubled[gfwmac_pkg::SYMBOL_BITS-1:0];
			end
			doubled = doubled << 1;
			if (doubled[gfwmac_pkg::SYMBOL_BITS]) begin
				doubled = doubled ^ gfwmac_pkg::FIELD_POLY[gfwmac_pkg::SYMBOL_BITS:0];
			end
		end
		return acc;
	endfunction

	// Scales every lane of a bus word by the coefficient. Lanes are read from
	// the top of the bus and packed back from the low end, first lane highest.
	function automatic logic [gfwmac_pkg::DATA_BITS-1:0] gf_scale_word(
			input logic [gfwmac_pkg::DATA_BITS-1:0] word,
			input logic [gfwmac_pkg::COEF_BITS-1:0] coef);
		logic [gfwmac_pkg::DATA_BITS-1:0] scaled;
		gfwmac_pkg::sym_t                 lane_sym;
		scaled = '0;
		for (int lane = 0; lane < gfwmac_pkg::LANE_COUNT; lane++) begin
			lane_sym = word[gfwmac_pkg::BUS_WIDTH - gfwmac_pkg::SYMBOL_BITS * (lane + 1)
				+: gfwmac_pkg::SYMBOL_BITS];
			scaled   = (scaled << gfwmac_pkg::SYMBOL_BITS) |
				gfwmac_pkg::DATA_BITS'(gf_mul_sym(lane_sym,
					coef[gfwmac_pkg::SYMBOL_BITS-1:0]));
		end
		return scaled;
	endfunction

	task automatic push_req(input logic [gfwmac_pkg::DATA_BITS-1:0] word,
			input logic [gfwmac_pkg::COEF_BITS-1:0] coef, input logic closes);
		word_req_t req;
		req.word   = word;
		req.coef   = coef;
		req.closes = closes;
		request_q.push_back(req);
	endtask

	// Queues one combination of random words. Lanes are biased towards the
	// zero and all-ones symbols, and coefficients towards zero, one and 0xFF,
	// so that the zero-operand rule and the reduction are hit often.
	task automatic queue_combination(input int words);
		logic [gfwmac_pkg::DATA_BITS-1:0] word;
		logic [gfwmac_pkg::COEF_BITS-1:0] coef;
		int                               pick;
		for (int w = 0; w < words; w++) begin
			for (int lane = 0; lane < gfwmac_pkg::DATA_BITS / 8; lane++) begin
				pick = $urandom_range(99);
				word[lane*8 +: 8] = (pick < 10) ? 8'h00 : (pick < 20) ? 8'hFF
					: 8'($urandom_range(255));
			end
			pick = $urandom_range(99);
			coef = (pick < 8) ? 8'h00 : (pick < 16) ? 8'h01 : (pick < 20) ? 8'hFF
				: 8'($urandom_range(255));
			push_req(word, coef, w == words - 1);
		end
	endtask

	// Holds the stimulus back until the driver is empty and every closing sum
	// owed by the block has been taken.
	task automatic wait_drained();
		while (request_q.size() != 0 || s_axis_tvalid || expected_sums_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Driver: a new request is presented at the falling edge once the previous
	// one has been taken (or none was pending). The receiver's ready is
	// re-rolled at every falling edge.
	always @(negedge clk) begin : sender
		word_req_t nxt;
		if (arst_n && (!s_axis_tvalid || req_taken)) begin
			if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = request_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {nxt.coef, nxt.word};
				s_axis_tlast  <= nxt.closes;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Monitor: at each rising edge an accepted request updates the predicted
	// sum, and an accepted result is checked against the oldest owed sum.
	always @(posedge clk) begin : monitor
		logic [gfwmac_pkg::DATA_BITS-1:0] owed;
		if (arst_n) begin
			req_taken <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				requests_taken++;
				run_length++;
				running_sum = running_sum ^
					gf_scale_word(s_axis_tdata[gfwmac_pkg::DATA_BITS-1:0],
						s_axis_tdata[gfwmac_pkg::DATA_BITS +: gfwmac_pkg::COEF_BITS]);
				if (s_axis_tlast) begin
					expected_sums_q.push_back(running_sum);
					running_sum = '0;
					if (run_length > longest_run) begin
						longest_run = run_length;
					end
					run_length = 0;
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_sums_q.size() == 0) begin
					$error("data_out: no sum expected, actual %h", m_axis_tdata);
					error_count++;
				end else begin
					owed = expected_sums_q.pop_front();
					sums_checked++;
					if (m_axis_tdata !== owed) begin
						$error("data_out mismatch: expected %h, actual %h", owed, m_axis_tdata);
						error_count++;
					end
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests, no stalls: zero and unit coefficients, zero and
		// all-ones words, reduction in every lane, words that cancel, and
		// combinations of one, two and three words.
		push_req(64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b1);
		push_req(64'hFFFF_FFFF_FFFF_FFFF, 8'h01, 1'b1);
		push_req(64'h0000_0000_0000_0000, 8'hFF, 1'b1);
		push_req(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1);
		push_req(64'h8080_8080_8080_8080, 8'h02, 1'b1);
		push_req(64'h0123_4567_89AB_CDEF, 8'h1D, 1'b1);
		push_req(64'hAAAA_AAAA_AAAA_AAAA, 8'hAA, 1'b0);
		push_req(64'h5555_5555_5555_5555, 8'h55, 1'b1);
		push_req(64'hDEAD_BEEF_00C0_FFEE, 8'h8E, 1'b0);
		push_req(64'hDEAD_BEEF_00C0_FFEE, 8'h8E, 1'b1);
		push_req(64'h00FF_00FF_00FF_00FF, 8'h80, 1'b0);
		push_req(64'hFF00_FF00_FF00_FF00, 8'h7F, 1'b0);
		push_req(64'h0102_0408_1020_4080, 8'hC3, 1'b1);
		push_req(64'h8000_0000_0000_0001, 8'h80, 1'b1);
		wait_drained();

		// Random combinations in three stall patterns; the bench drains fully
		// between them so that the sender sits idle with nothing owed.
		for (int phase = 0; phase < 3; phase++) begin : random_phase
			int queued;
			int pick;
			send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 48 : 0;
			recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 38 : 0;
			queued = 0;
			while (queued < 517) begin
				pick = $urandom_range(99);
				pick = (pick < 70) ? $urandom_range(6, 1) : (pick < 95) ? $urandom_range(20, 7)
					: $urandom_range(64, 21);
				queue_combination(pick);
				queued += pick;
			end
			wait_drained();
		end

		// Further idle clocks catch any result the block emits unasked.
		repeat (16) @(posedge clk);
		$display("Checked %0d closing sums over %0d requests; longest combination %0d words.",
			sums_checked, requests_taken, longest_run);
		$display("Stall patterns: sender-heavy, receiver-heavy and none, with full drains.");
		if (error_count == 0) begin
			$display("tb_gf256_word_multiply_accumulate: PASS");
		end else begin
			$display("tb_gf256_word_multiply_accumulate: FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#500000;
		$display("Run timed out with %0d sums still owed.", expected_sums_q.size());
		$display("tb_gf256_word_multiply_accumulate: FAIL");
		$finish;
	end

endmodule

### sim.f
src/gfwmac_pkg.sv
src/gfwmac_word_mul.sv
src/gf256_word_multiply_accumulate.sv
tb/tb_gf256_word_multiply_accumulate.sv
